>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Clocked implication, off while reset is held.
`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wlrs_pkg.sv
// Types and constants of the wear-level record block scanner.
`timescale 1ns / 1ps

package wlrs_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_COUNT = 2'd2;

  localparam int CFG_DATA_W = 64;
  localparam int POS_W      = 11;
  localparam int ELEN_W     = 9;
  localparam int QDEPTH     = 2;

  localparam logic [7:0]  HEAD_RESET  = 8'h91;
  localparam logic [63:0] TABLE_RESET = 64'd513;
  localparam logic [3:0]  COUNT_RESET = 4'd2;
  localparam logic [7:0]  BYTE_ERASED = 8'hFF;
  localparam logic [ELEN_W-1:0] RECORD_OVERHEAD = 9'd5;

  typedef enum logic [2:0] {
    KIND_DATA,
    KIND_VALID,
    KIND_BAD_SUM,
    KIND_UNKNOWN,
    KIND_BLOCK_ERASE
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       rec_index;
    logic [15:0]      addr;
    logic [7:0]       hlen;
    logic [POS_W-1:0] pos;
    logic [7:0]       payload;
    logic             last;
  } entry_t;

endpackage

>>> hw/rtl/wlrs_front.sv
// Front end: configuration registers, record parser and result classification.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wlrs_front #(
  parameter int BLOCK_BYTES   = 64,
  parameter int SPACE_BYTES   = 2048,
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [wlrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte_in,
  input  logic                            in_block_end,
  input  logic                            q_full,
  output logic                            q_push,
  output wlrs_pkg::entry_t                q_data
);

  localparam int OW = $clog2(BLOCK_BYTES);
  localparam int BLOCK_COUNT = (SPACE_BYTES / BLOCK_BYTES) > 0 ? (SPACE_BYTES / BLOCK_BYTES) : 1;
  localparam int BN_W = BLOCK_COUNT > 1 ? $clog2(BLOCK_COUNT) : 1;
  localparam logic [OW-1:0]   OFF_LAST   = OW'(BLOCK_BYTES - 1);
  localparam logic [BN_W-1:0] BLOCK_LAST = BN_W'(BLOCK_COUNT - 1);
  localparam logic [wlrs_pkg::POS_W-1:0] BLOCK_STEP = wlrs_pkg::POS_W'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_INDEX,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_LENGTH,
    PH_DATA,
    PH_CHECK
  } phase_t;

  logic [7:0]  head_r;
  logic [63:0] table_r;
  logic [3:0]  count_r;

  phase_t                     phase_r, phase_nxt;
  logic [BN_W-1:0]            block_r, block_nxt;
  logic [wlrs_pkg::POS_W-1:0] base_r, base_nxt;
  logic [OW-1:0]              offset_r, offset_nxt;
  logic [OW-1:0]              rstart_r, rstart_nxt;
  logic [7:0]                 hidx_r, hidx_nxt;
  logic [15:0]                haddr_r, haddr_nxt;
  logic [7:0]                 hlen_r, hlen_nxt;
  logic [7:0]                 left_r, left_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic                       known_r, known_nxt;
  logic                       nonff_r, nonff_nxt;
  logic                       head_seen_r, head_seen_nxt;

  logic                       accept;
  logic                       end_w;
  logic                       hit;
  logic [7:0]                 b;
  logic [wlrs_pkg::POS_W-1:0] pos_rec;
  logic [wlrs_pkg::POS_W-1:0] pos_cur;
  wlrs_pkg::entry_t           res;
  logic                       res_valid;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_byte_in;
  assign end_w    = in_block_end || (offset_r >= OFF_LAST);
  assign pos_rec  = base_r + wlrs_pkg::POS_W'(rstart_r);
  assign pos_cur  = base_r + wlrs_pkg::POS_W'(offset_r);
  assign q_push   = accept && res_valid;
  assign q_data   = res;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if ((4'(i) < count_r) && (table_r[8*i +: 8] == b)) hit = 1'b1;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    block_nxt     = block_r;
    base_nxt      = base_r;
    offset_nxt    = offset_r;
    rstart_nxt    = rstart_r;
    hidx_nxt      = hidx_r;
    haddr_nxt     = haddr_r;
    hlen_nxt      = hlen_r;
    left_nxt      = left_r;
    sum_nxt       = sum_r;
    known_nxt     = known_r;
    nonff_nxt     = nonff_r || (b != wlrs_pkg::BYTE_ERASED);
    head_seen_nxt = head_seen_r;
    res_valid     = 1'b0;
    res.kind      = wlrs_pkg::KIND_DATA;
    res.rec_index = hidx_r;
    res.addr      = haddr_r;
    res.hlen      = hlen_r;
    res.pos       = pos_rec;
    res.payload   = 8'd0;
    res.last      = 1'b1;

    case (phase_r)
      PH_HUNT: begin
        if (b == head_r) begin
          head_seen_nxt = 1'b1;
          rstart_nxt    = offset_r;
          sum_nxt       = b;
          phase_nxt     = PH_INDEX;
        end
      end
      PH_INDEX: begin
        hidx_nxt  = b;
        known_nxt = hit;
        sum_nxt   = sum_r + b;
        phase_nxt = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        haddr_nxt = {b, 8'd0};
        sum_nxt   = sum_r + b;
        phase_nxt = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        haddr_nxt = {haddr_r[15:8], b};
        sum_nxt   = sum_r + b;
        phase_nxt = PH_LENGTH;
      end
      PH_LENGTH: begin
        hlen_nxt = b;
        if (b == 8'd0) begin
          res_valid = 1'b1;
          res.kind  = known_r ? wlrs_pkg::KIND_BAD_SUM : wlrs_pkg::KIND_UNKNOWN;
          res.hlen  = b;
          phase_nxt = PH_HUNT;
        end else begin
          sum_nxt   = sum_r + b;
          left_nxt  = b - 8'd1;
          phase_nxt = (b == 8'd1) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        if (known_r) begin
          res_valid   = 1'b1;
          res.kind    = wlrs_pkg::KIND_DATA;
          res.pos     = pos_cur;
          res.payload = b;
        end
        sum_nxt  = sum_r + b;
        left_nxt = left_r - 8'd1;
        if (left_r == 8'd1) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        res_valid = 1'b1;
        if (!known_r) res.kind = wlrs_pkg::KIND_UNKNOWN;
        else if (sum_r == b) res.kind = wlrs_pkg::KIND_VALID;
        else res.kind = wlrs_pkg::KIND_BAD_SUM;
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase

    if (end_w) begin
      if (nonff_nxt && !head_seen_nxt) begin
        res_valid     = 1'b1;
        res.kind      = wlrs_pkg::KIND_BLOCK_ERASE;
        res.rec_index = 8'd0;
        res.addr      = 16'd0;
        res.hlen      = 8'd0;
        res.pos       = base_r;
        res.payload   = 8'd0;
      end
      phase_nxt     = PH_HUNT;
      nonff_nxt     = 1'b0;
      head_seen_nxt = 1'b0;
      offset_nxt    = '0;
      if (block_r == BLOCK_LAST) begin
        block_nxt = '0;
        base_nxt  = '0;
      end else begin
        block_nxt = block_r + BN_W'(1);
        base_nxt  = base_r + BLOCK_STEP;
      end
    end else begin
      offset_nxt = offset_r + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= wlrs_pkg::HEAD_RESET;
      table_r     <= wlrs_pkg::TABLE_RESET;
      count_r     <= wlrs_pkg::COUNT_RESET;
      phase_r     <= PH_HUNT;
      block_r     <= '0;
      base_r      <= '0;
      offset_r    <= '0;
      rstart_r    <= '0;
      hidx_r      <= '0;
      haddr_r     <= '0;
      hlen_r      <= '0;
      left_r      <= '0;
      sum_r       <= '0;
      known_r     <= 1'b0;
      nonff_r     <= 1'b0;
      head_seen_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          wlrs_pkg::CFG_HEAD_BYTE:   head_r  <= cfg_data[7:0];
          wlrs_pkg::CFG_INDEX_TABLE: table_r <= cfg_data;
          wlrs_pkg::CFG_INDEX_COUNT: count_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        block_r     <= block_nxt;
        base_r      <= base_nxt;
        offset_r    <= offset_nxt;
        rstart_r    <= rstart_nxt;
        hidx_r      <= hidx_nxt;
        haddr_r     <= haddr_nxt;
        hlen_r      <= hlen_nxt;
        left_r      <= left_nxt;
        sum_r       <= sum_nxt;
        known_r     <= known_nxt;
        nonff_r     <= nonff_nxt;
        head_seen_r <= head_seen_nxt;
      end
    end
  end

  `ASSERT_IMPL(a_parse_needs_head, clk, rst_n, phase_r != PH_HUNT, head_seen_r, "record parse without head in block")
  `ASSERT_CLK(a_end_to_hunt, clk, rst_n, (accept && end_w) |=> (phase_r == PH_HUNT && offset_r == '0), "block end did not restart hunt")

endmodule

>>> hw/rtl/wlrs_fifo.sv
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wlrs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wlrs_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output wlrs_pkg::entry_t pop_data,
  output logic             empty
);

  localparam int QW = $clog2(wlrs_pkg::QDEPTH);

  wlrs_pkg::entry_t mem [wlrs_pkg::QDEPTH];
  logic [QW-1:0]    wr_ptr_r;
  logic [QW-1:0]    rd_ptr_r;
  logic [QW:0]      count_r;

  assign full     = (count_r == (QW+1)'(wlrs_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QW'(1);
      if (push && !pop) count_r <= count_r + (QW+1)'(1);
      else if (pop && !push) count_r <= count_r - (QW+1)'(1);
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= (QW+1)'(wlrs_pkg::QDEPTH), "queue count overflow")
  `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

>>> hw/rtl/wlrs_back.sv
// Back end: formats queued results into the registered output beat.
`timescale 1ns / 1ps

module wlrs_back #(
  parameter int BLOCK_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  wlrs_pkg::entry_t                    q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_kind,
  output logic [7:0]                          out_record_index,
  output logic [15:0]                         out_stored_address,
  output logic [7:0]                          out_data_length,
  output logic [wlrs_pkg::POS_W-1:0]          out_position,
  output logic [7:0]                          out_payload_byte,
  output logic [wlrs_pkg::ELEN_W-1:0]         out_erase_length,
  output logic                                out_last
);

  logic                         valid_r;
  logic [2:0]                   kind_r;
  logic [7:0]                   idx_r;
  logic [15:0]                  addr_r;
  logic [7:0]                   dlen_r;
  logic [wlrs_pkg::POS_W-1:0]   pos_r;
  logic [7:0]                   pay_r;
  logic [wlrs_pkg::ELEN_W-1:0]  elen_r;
  logic                         last_r;
  logic [7:0]                   dlen_nxt;
  logic [wlrs_pkg::ELEN_W-1:0]  elen_nxt;

  assign q_pop = !q_empty && (!valid_r || out_ready);

  always_comb begin
    dlen_nxt = (q_data.hlen == 8'd0) ? 8'd0 : q_data.hlen - 8'd1;
    case (q_data.kind)
      wlrs_pkg::KIND_BAD_SUM,
      wlrs_pkg::KIND_UNKNOWN:     elen_nxt = {1'b0, q_data.hlen} + wlrs_pkg::RECORD_OVERHEAD;
      wlrs_pkg::KIND_BLOCK_ERASE: elen_nxt = wlrs_pkg::ELEN_W'(BLOCK_BYTES);
      default:                    elen_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_data.kind;
      idx_r  <= q_data.rec_index;
      addr_r <= q_data.addr;
      dlen_r <= dlen_nxt;
      pos_r  <= q_data.pos;
      pay_r  <= q_data.payload;
      elen_r <= elen_nxt;
      last_r <= q_data.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_record_index   = idx_r;
  assign out_stored_address = addr_r;
  assign out_data_length    = dlen_r;
  assign out_position       = pos_r;
  assign out_payload_byte   = pay_r;
  assign out_erase_length   = elen_r;
  assign out_last           = last_r;

endmodule

>>> hw/rtl/wear_level_record_block_scanner.sv
// Top level of the wear-level record block scanner.
// Usage:
//   Input channel (in_valid/in_ready): one beat per raw block byte, with
//   in_block_end high on the last byte of a block; a block also closes on its
//   BLOCK_BYTES-th byte.
//   Output channel (out_valid/out_ready): at most one result beat per input
//   beat: tentative data bytes, record verdicts and block erase requests,
//   each with out_last set.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0
//   head byte, 1 index table, 2 index count. Write only while idle.
// Result path: the queue takes a result beat at the edge that accepts its
//   byte, and the output register, which drives out_valid, takes it from the
//   queue once that register is empty or out_ready is high.
// Throughput: one byte per cycle while the queue has room, set by the parser
//   update on each accepted byte and the one-beat-per-cycle output register.
// Reset: synchronous, active low; parser returns to head hunt at block 0 and
//   the configuration registers take their defaults. No clearing pass.
// Stall: a two-entry queue and the output register absorb a stalled
//   receiver; in_ready drops once the queue is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wear_level_record_block_scanner #(
  parameter int BLOCK_BYTES   = 64,
  parameter int SPACE_BYTES   = 2048,
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wlrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte_in,
  input  logic                            in_block_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_kind,
  output logic [7:0]                      out_record_index,
  output logic [15:0]                     out_stored_address,
  output logic [7:0]                      out_data_length,
  output logic [wlrs_pkg::POS_W-1:0]      out_position,
  output logic [7:0]                      out_payload_byte,
  output logic [wlrs_pkg::ELEN_W-1:0]     out_erase_length,
  output logic                            out_last
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  wlrs_pkg::entry_t q_wdata;
  wlrs_pkg::entry_t q_rdata;

  assign cfg_ready = 1'b1;

  wlrs_front #(
    .BLOCK_BYTES   (BLOCK_BYTES),
    .SPACE_BYTES   (SPACE_BYTES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_in   (in_byte_in),
    .in_block_end (in_block_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  wlrs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  wlrs_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_record_index   (out_record_index),
    .out_stored_address (out_stored_address),
    .out_data_length    (out_data_length),
    .out_position       (out_position),
    .out_payload_byte   (out_payload_byte),
    .out_erase_length   (out_erase_length),
    .out_last           (out_last)
  );

  `ASSERT_IMPL(a_push_has_room, clk, rst_n, q_push, !q_full, "result pushed into full queue")

endmodule
